@@ hdl/hrm_pkg.sv @@
`default_nettype none
package hrm_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DivBits    = 54;
  localparam int unsigned ExpTerms   = 12;

  localparam logic signed [54:0] Ln2Q30   = 55'sd744261118;
  localparam logic signed [54:0] SixQ30   = 55'sd6442450944;
  localparam logic        [32:0] Ln2U     = 33'd744261118;
  localparam logic        [31:0] OneQ30   = 32'd1073741824;
  localparam logic        [41:0] HalfQ31  = 42'd1073741824;

  // input word
  typedef struct packed {
    logic               func;
    logic        [7:0]  table_index;
    logic signed [23:0] table_value;
    logic        [7:0]  sample_c0;
    logic        [7:0]  sample_c1;
    logic        [7:0]  sample_c2;
    logic signed [23:0] log_exposure;
    logic               last_exposure;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] radiance_from_c2;
    logic [7:0] radiance_from_c1;
    logic [7:0] radiance_from_c0;
  } out_word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       tbl_wr;
    logic       load_in;
    logic       acc_mul;
    logic       acc_add;
    logic       clr_acc;
    logic       div_init_x;
    logic       div_init_t;
    logic       div_step;
    logic       rng;
    logic       k_step;
    logic       ser_init;
    logic       mul;
    logic       term;
    logic       fin;
    logic       rad_zero;
    logic       load_out;
    logic [1:0] chan;
    logic [3:0] iter;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic w_zero;
    logic x_out;
    logic u_ge;
    logic out_free;
    logic last;
  } sts_t;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_RD     = 13'b0000000000010,
    ST_MUL_A  = 13'b0000000000100,
    ST_ADD_A  = 13'b0000000001000,
    ST_F_INIT = 13'b0000000010000,
    ST_F_DIV  = 13'b0000000100000,
    ST_F_RNG  = 13'b0000001000000,
    ST_F_K    = 13'b0000010000000,
    ST_F_MUL  = 13'b0000100000000,
    ST_F_DIVI = 13'b0001000000000,
    ST_F_TERM = 13'b0010000000000,
    ST_F_FIN  = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_e;

  // hat weight of one channel byte
  function automatic logic [7:0] hat_weight(input logic [7:0] z);
    logic [7:0] w;
    if (z <= 8'd128) begin
      w = z;
    end else if (z < 8'd250) begin
      w = 8'(9'd256 - {1'b0, z});
    end else begin
      w = 8'd6;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

@@ hdl/hrm_ctrl.sv @@
`default_nettype none
module hrm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_func_i,
  output logic               in_stall_o,
  input  wire hrm_pkg::sts_t sts_i,
  output hrm_pkg::cmd_t      cmd_o
);

  hrm_pkg::state_e state_q, state_d;
  logic [1:0] chan_q, chan_d;
  logic [3:0] iter_q, iter_d;
  logic [5:0] cnt_q, cnt_d;
  logic       ser_q, ser_d;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrm_pkg::ST_IDLE;
      chan_q  <= '0;
      iter_q  <= '0;
      cnt_q   <= '0;
      ser_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      iter_q  <= iter_d;
      cnt_q   <= cnt_d;
      ser_q   <= ser_d;
    end
  end

  assign in_stall_o = (state_q != hrm_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    iter_d  = iter_q;
    cnt_d   = cnt_q;
    ser_d   = ser_q;
    cmd_o   = '0;
    cmd_o.chan = chan_q;
    cmd_o.iter = iter_q;
    case (state_q)
      hrm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i) begin
            cmd_o.load_in = 1'b1;
            chan_d  = '0;
            state_d = hrm_pkg::ST_RD;
          end else begin
            cmd_o.tbl_wr = 1'b1;
          end
        end
      end
      hrm_pkg::ST_RD: state_d = hrm_pkg::ST_MUL_A;
      hrm_pkg::ST_MUL_A: begin
        cmd_o.acc_mul = 1'b1;
        state_d = hrm_pkg::ST_ADD_A;
      end
      hrm_pkg::ST_ADD_A: begin
        cmd_o.acc_add = 1'b1;
        if (chan_q == 2'd2) begin
          chan_d  = '0;
          state_d = sts_i.last ? hrm_pkg::ST_F_INIT : hrm_pkg::ST_IDLE;
        end else begin
          chan_d  = chan_q + 2'd1;
          state_d = hrm_pkg::ST_RD;
        end
      end
      hrm_pkg::ST_F_INIT: begin
        if (sts_i.w_zero) begin
          cmd_o.rad_zero = 1'b1;
          chan_d  = chan_q + 2'd1;
          state_d = (chan_q == 2'd2) ? hrm_pkg::ST_DONE : hrm_pkg::ST_F_INIT;
        end else begin
          cmd_o.div_init_x = 1'b1;
          cnt_d   = '0;
          ser_d   = 1'b0;
          state_d = hrm_pkg::ST_F_DIV;
        end
      end
      hrm_pkg::ST_F_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(hrm_pkg::DivBits - 1)) begin
          state_d = ser_q ? hrm_pkg::ST_F_TERM : hrm_pkg::ST_F_RNG;
        end
      end
      hrm_pkg::ST_F_RNG: begin
        cmd_o.rng = 1'b1;
        if (sts_i.x_out) begin
          chan_d  = chan_q + 2'd1;
          state_d = (chan_q == 2'd2) ? hrm_pkg::ST_DONE : hrm_pkg::ST_F_INIT;
        end else begin
          state_d = hrm_pkg::ST_F_K;
        end
      end
      hrm_pkg::ST_F_K: begin
        if (sts_i.u_ge) begin
          cmd_o.k_step = 1'b1;
        end else begin
          cmd_o.ser_init = 1'b1;
          iter_d  = 4'd1;
          state_d = hrm_pkg::ST_F_MUL;
        end
      end
      hrm_pkg::ST_F_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = hrm_pkg::ST_F_DIVI;
      end
      hrm_pkg::ST_F_DIVI: begin
        cmd_o.div_init_t = 1'b1;
        cnt_d   = '0;
        ser_d   = 1'b1;
        state_d = hrm_pkg::ST_F_DIV;
      end
      hrm_pkg::ST_F_TERM: begin
        cmd_o.term = 1'b1;
        if (iter_q == 4'(hrm_pkg::ExpTerms)) begin
          state_d = hrm_pkg::ST_F_FIN;
        end else begin
          iter_d  = iter_q + 4'd1;
          state_d = hrm_pkg::ST_F_MUL;
        end
      end
      hrm_pkg::ST_F_FIN: begin
        cmd_o.fin = 1'b1;
        chan_d  = chan_q + 2'd1;
        state_d = (chan_q == 2'd2) ? hrm_pkg::ST_DONE : hrm_pkg::ST_F_INIT;
      end
      hrm_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clr_acc  = 1'b1;
          chan_d  = '0;
          state_d = hrm_pkg::ST_IDLE;
        end
      end
      default: state_d = hrm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/hrm_dpath.sv @@
`default_nettype none
module hrm_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hrm_pkg::in_word_t in_word_i,
  input  wire hrm_pkg::cmd_t     cmd_i,
  output hrm_pkg::sts_t          sts_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output hrm_pkg::out_word_t     out_word_o
);

  logic signed [23:0] tbl_mem [hrm_pkg::TableDepth];
  logic signed [23:0] rd_q;
  hrm_pkg::in_word_t  in_q;

  logic signed [39:0] wls_q [3];
  logic        [11:0] ws_q  [3];
  logic signed [33:0] prod_q;

  logic [53:0] num_q;
  logic [11:0] rem_q;
  logic [11:0] den_q;
  logic        neg_q;

  logic [32:0] u_q;
  logic [3:0]  k_q;
  logic [31:0] e_q;
  logic [30:0] term_q;
  logic [60:0] prod2_q;
  logic [7:0]  rad_q [3];

  logic              out_valid_q;
  hrm_pkg::out_word_t out_q;

  logic [7:0]         zsel;
  logic [7:0]         wsel;
  logic signed [24:0] diff;
  logic [12:0]        rem_sh;
  logic               qbit;
  logic signed [54:0] xs;
  logic signed [39:0] s_cur;
  logic [39:0]        s_mag;
  logic [41:0]        ek;
  logic [10:0]        val;

  // channel byte and weight of the selected channel
  always_comb begin
    case (cmd_i.chan)
      2'd0:    zsel = in_q.sample_c0;
      2'd1:    zsel = in_q.sample_c1;
      default: zsel = in_q.sample_c2;
    endcase
  end
  assign wsel = hrm_pkg::hat_weight(zsel);
  assign diff = 25'(rd_q) - 25'(in_q.log_exposure);

  // response table
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) begin
      tbl_mem[in_word_i.table_index] <= in_word_i.table_value;
    end
    rd_q <= tbl_mem[zsel];
  end

  // sample capture and weighted product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_word_i;
    end
    if (cmd_i.acc_mul) begin
      prod_q <= 34'(diff * $signed({1'b0, wsel}));
    end
  end

  // accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        wls_q[c] <= '0;
        ws_q[c]  <= '0;
      end
    end else if (cmd_i.clr_acc) begin
      for (int c = 0; c < 3; c++) begin
        wls_q[c] <= '0;
        ws_q[c]  <= '0;
      end
    end else if (cmd_i.acc_add) begin
      wls_q[cmd_i.chan] <= wls_q[cmd_i.chan] + 40'(prod_q);
      ws_q[cmd_i.chan]  <= ws_q[cmd_i.chan] + 12'(wsel);
    end
  end

  assign s_cur = wls_q[cmd_i.chan];
  assign s_mag = s_cur[39] ? 40'(-s_cur) : 40'(s_cur);

  // restoring divider step
  assign rem_sh = {rem_q, num_q[53]};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  // signed quotient and range
  assign xs = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

  assign ek  = 42'(e_q) << k_q;
  assign val = 11'((ek + hrm_pkg::HalfQ31) >> 31);

  // exponent datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init_x) begin
      num_q <= 54'(s_mag) << (30 - hrm_pkg::FracBits);
      den_q <= ws_q[cmd_i.chan];
      neg_q <= s_cur[39];
      rem_q <= '0;
    end else if (cmd_i.div_init_t) begin
      num_q <= 54'(prod2_q[60:30]);
      den_q <= 12'(cmd_i.iter);
      neg_q <= 1'b0;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[52:0], qbit};
      rem_q <= qbit ? 12'(rem_sh - {1'b0, den_q}) : rem_sh[11:0];
    end
    if (cmd_i.rng) begin
      u_q <= 33'(xs + hrm_pkg::Ln2Q30);
      k_q <= '0;
    end else if (cmd_i.k_step) begin
      u_q <= u_q - hrm_pkg::Ln2U;
      k_q <= k_q + 4'd1;
    end
    if (cmd_i.ser_init) begin
      e_q    <= hrm_pkg::OneQ30;
      term_q <= 31'(hrm_pkg::OneQ30);
    end else if (cmd_i.term) begin
      term_q <= num_q[30:0];
      e_q    <= e_q + 32'(num_q[30:0]);
    end
    if (cmd_i.mul) begin
      prod2_q <= 61'(term_q) * 61'(u_q[29:0]);
    end
    if (cmd_i.rad_zero) begin
      rad_q[cmd_i.chan] <= '0;
    end else if (cmd_i.rng && xs < -hrm_pkg::Ln2Q30) begin
      rad_q[cmd_i.chan] <= '0;
    end else if (cmd_i.rng && xs >= hrm_pkg::SixQ30) begin
      rad_q[cmd_i.chan] <= 8'd255;
    end else if (cmd_i.fin) begin
      rad_q[cmd_i.chan] <= (val > 11'd255) ? 8'd255 : val[7:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.radiance_from_c2 <= rad_q[2];
      out_q.radiance_from_c1 <= rad_q[1];
      out_q.radiance_from_c0 <= rad_q[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // status
  assign sts_o.w_zero   = (ws_q[cmd_i.chan] == '0);
  assign sts_o.x_out    = (xs < -hrm_pkg::Ln2Q30) || (xs >= hrm_pkg::SixQ30);
  assign sts_o.u_ge     = (u_q >= hrm_pkg::Ln2U);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.last     = in_q.last_exposure;

endmodule
`default_nettype wire

@@ hdl/hdr_radiance_merge.sv @@
// hdr radiance merge: several exposures of one rgb pixel into radiance
//
// input channel: in_valid_i / in_stall_o with in_word_i. a word with func 0
// writes one response table entry without stalling the input. a word with
// func 1 is one exposure sample: its three channels are looked up and
// accumulated one after another, each by a table read, a multiply and an
// add. on a sample marked last_exposure each channel of nonzero weight
// runs through a 54 bit shift-subtract divider and, if its quotient is in
// range, through a range reduction loop and a 12 term series, each term
// a multiply plus a division through the same divider.
// out channel: out_valid_o / out_stall_i with out_word_o, one word per
// pixel from an output register. a stalled word holds; the next pixel's
// samples are taken meanwhile, and a finished result waits for the
// register to free before it is loaded.
// reset clears the accumulators and the control; the response table is
// not cleared and must be loaded before samples use it.
`default_nettype none
module hdr_radiance_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hrm_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hrm_pkg::out_word_t      out_word_o
);

  hrm_pkg::cmd_t cmd;
  hrm_pkg::sts_t sts;

  // sequencer
  hrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_word_i.func),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  hrm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

@@ verif/hdr_radiance_merge_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module hdr_radiance_merge_tb;

  localparam longint Ln2Fix   = 744261118;
  localparam longint OneFix   = 1073741824;
  localparam int     ItemGoal = 1750;
  localparam int     DrainWait = 3000;
  localparam longint CycleLimit = 20000000;

  // exposure merge predictor with its own response curve and accumulators
  class radiance_scoreboard;
    logic signed [23:0] curve [256];
    logic [39:0]        log_acc [3];
    logic [11:0]        wt_acc [3];
    hrm_pkg::out_word_t pixel_q [$];
    int                 errors;
    int                 pixels;
    int                 loads;

    function new();
      for (int c = 0; c < 3; c++) begin
        log_acc[c] = '0;
        wt_acc[c]  = '0;
      end
      errors = 0;
      pixels = 0;
      loads  = 0;
    endfunction

    function logic [7:0] hat(input logic [7:0] z);
      if (z <= 8'd128) return z;
      if (z < 8'd250) return 8'(9'd256 - {1'b0, z});
      return 8'd6;
    endfunction

    // exp of the mean log value, rounded and clipped to a byte
    function logic [7:0] merge_channel(input logic [39:0] acc, input logic [11:0] wt);
      longint s, x, u, k, r, wl;
      longint unsigned e, term, val;
      if (wt == 0) return 8'd0;
      s  = longint'($signed(acc));
      wl = longint'(wt);
      x  = (s * 16384) / wl;
      if (x < -Ln2Fix) return 8'd0;
      if (x >= 6 * OneFix) return 8'd255;
      u = x + Ln2Fix;
      k = u / Ln2Fix;
      r = u - k * Ln2Fix;
      e = OneFix;
      term = OneFix;
      for (int i = 1; i <= 12; i++) begin
        term = (term * longint'(r)) >> 30;
        term = term / i;
        e = e + term;
      end
      val = ((e << k) + OneFix) >> 31;
      return (val > 255) ? 8'd255 : val[7:0];
    endfunction

    function void note_word(input hrm_pkg::in_word_t w);
      logic [7:0] z [3];
      logic [7:0] wt;
      longint diff;
      hrm_pkg::out_word_t res;
      if (!w.func) begin
        curve[w.table_index] = w.table_value;
        loads++;
        return;
      end
      z[0] = w.sample_c0;
      z[1] = w.sample_c1;
      z[2] = w.sample_c2;
      for (int c = 0; c < 3; c++) begin
        wt = hat(z[c]);
        diff = longint'(curve[z[c]]) - longint'(w.log_exposure);
        log_acc[c] = 40'(log_acc[c] + diff * longint'(wt));
        wt_acc[c]  = 12'(wt_acc[c] + wt);
      end
      if (!w.last_exposure) return;
      res.radiance_from_c2 = merge_channel(log_acc[2], wt_acc[2]);
      res.radiance_from_c1 = merge_channel(log_acc[1], wt_acc[1]);
      res.radiance_from_c0 = merge_channel(log_acc[0], wt_acc[0]);
      pixel_q = {pixel_q, res};
      for (int c = 0; c < 3; c++) begin
        log_acc[c] = '0;
        wt_acc[c]  = '0;
      end
    endfunction

    function void check_word(input hrm_pkg::out_word_t got);
      hrm_pkg::out_word_t want;
      if (pixel_q.size() == 0) begin
        $error("radiance word with none expected: %h", got);
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      pixels++;
      if (got.radiance_from_c2 !== want.radiance_from_c2) begin
        $error("radiance_from_c2 expected %0d got %0d", want.radiance_from_c2,
               got.radiance_from_c2);
        errors++;
      end
      if (got.radiance_from_c1 !== want.radiance_from_c1) begin
        $error("radiance_from_c1 expected %0d got %0d", want.radiance_from_c1,
               got.radiance_from_c1);
        errors++;
      end
      if (got.radiance_from_c0 !== want.radiance_from_c0) begin
        $error("radiance_from_c0 expected %0d got %0d", want.radiance_from_c0,
               got.radiance_from_c0);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  hrm_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  hrm_pkg::out_word_t out_word;

  radiance_scoreboard sb;
  int     burst_left;
  int     sent;
  longint cycles;
  int     stall_mode;

  hdr_radiance_merge dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
  end

  // receiver stall pattern; its mode is redrawn when the low bits of the cycle counter are zero
  always @(posedge clk_i) begin
    if (cycles[8:0] == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) != 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // one word through the sender, with bursts and gaps
  task automatic send_word(input hrm_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic signed [23:0] v);
    hrm_pkg::in_word_t w;
    w = hrm_pkg::in_word_t'(82'({$urandom, $urandom, $urandom}));
    w.func        = 1'b0;
    w.table_index = idx;
    w.table_value = v;
    send_word(w);
  endtask

  task automatic send_sample(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic signed [23:0] lexp,
                             input logic last);
    hrm_pkg::in_word_t w;
    w = hrm_pkg::in_word_t'(82'({$urandom, $urandom, $urandom}));
    w.func          = 1'b1;
    w.sample_c0     = c0;
    w.sample_c1     = c1;
    w.sample_c2     = c2;
    w.log_exposure  = lexp;
    w.last_exposure = last;
    send_word(w);
  endtask

  task automatic wait_all_merged();
    in_valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(245, 255));
      2: return 8'($urandom_range(125, 132));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_lexp();
    if ($urandom_range(0, 15) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 300000)) - 150000);
  endfunction

  // plausible response curve value, sometimes anything
  function automatic logic signed [23:0] pick_curve(input logic [7:0] z);
    if ($urandom_range(0, 15) == 0) return 24'($urandom);
    return 24'(-200000 + int'(z) * 1500 + int'($urandom_range(0, 40000)) - 20000);
  endfunction

  initial begin
    int n;
    int idx;
    sb = new();
    in_valid   = 1'b0;
    in_word    = '0;
    out_stall  = 1'b0;
    stall_mode = 0;
    burst_left = 0;
    sent       = 0;
    rst_ni     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole response curve so no sample reads an unwritten entry
    for (int z = 0; z < 256; z++) load_entry(8'(z), pick_curve(8'(z)));

    // directed: curve extremes, hat knees, zero weight, exposure extremes
    load_entry(8'd200, 24'sh7FFFFF);
    load_entry(8'd10, 24'sh800000);
    send_sample(8'd200, 8'd200, 8'd200, 24'sd0, 1'b1);
    send_sample(8'd10, 8'd10, 8'd10, 24'sd0, 1'b1);
    send_sample(8'd0, 8'd0, 8'd0, 24'sd1000, 1'b1);
    send_sample(8'd0, 8'd128, 8'd255, 24'sd0, 1'b1);
    send_sample(8'd129, 8'd249, 8'd250, 24'sd0, 1'b1);
    send_sample(8'd64, 8'd128, 8'd192, 24'sh800000, 1'b1);
    send_sample(8'd64, 8'd128, 8'd192, 24'sh7FFFFF, 1'b1);
    send_sample(8'd30, 8'd128, 8'd250, -24'sd50000, 1'b0);
    load_entry(8'd77, 24'sd12345);
    send_sample(8'd90, 8'd140, 8'd255, 24'sd0, 1'b0);
    send_sample(8'd100, 8'd77, 8'd1, 24'sd60000, 1'b1);
    send_sample(8'd0, 8'd255, 8'd0, 24'sd0, 1'b0);
    send_sample(8'd0, 8'd0, 8'd0, 24'sd0, 1'b1);
    wait_all_merged();

    // random pixels, mostly well formed, occasional reloads and overflows
    while (sent < ItemGoal) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(0, 255);
        load_entry(8'(idx), pick_curve(8'(idx)));
      end else begin
        n = ($urandom_range(0, 30) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 40) == 0) begin
            idx = $urandom_range(0, 255);
            load_entry(8'(idx), pick_curve(8'(idx)));
          end
          send_sample(pick_byte(), pick_byte(), pick_byte(), pick_lexp(), i == n - 1);
        end
      end
      if ($urandom_range(0, 150) == 0) wait_all_merged();
    end

    wait_all_merged();
    repeat (DrainWait) @(posedge clk_i);
    $display("merged %0d pixels from %0d words, %0d of them curve loads",
             sb.pixels, sent, sb.loads);
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/hrm_pkg.sv
hdl/hrm_ctrl.sv
hdl/hrm_dpath.sv
hdl/hdr_radiance_merge.sv
verif/hdr_radiance_merge_tb.sv
